// ----- rtl/core/jdq_pkg.sv -----
// Shared widths, codes and constant tables of the JPEG dequantizer.
package jdq_pkg;

  localparam int NUM_TABLES_DEF = 4;

  localparam int MODE_W     = 1;
  localparam int TID_W      = 2;
  localparam int POS_W      = 6;
  localparam int VAL_W      = 8;
  localparam int COEF_W     = 12;
  localparam int PRESCALE_W = 14;
  localparam int ENTRY_W    = VAL_W + PRESCALE_W;   // 22
  localparam int RES_W      = 26;
  localparam int SHIFT      = 8;
  localparam int PROD_W     = COEF_W + ENTRY_W + 1; // signed coef x unsigned entry

  localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_DEQUANT = 1'b1;

  // zigzag index -> row-major index
  localparam logic [POS_W-1:0] ZZ_TO_NAT [64] = '{
     6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // AAN IDCT prescale s[row]*s[col]*8192, truncated, row-major
  localparam logic [PRESCALE_W-1:0] PRESCALE [64] = '{
     14'd8192, 14'd11362, 14'd10703,  14'd9632,  14'd8192,  14'd6436,  14'd4433,  14'd2260,
    14'd11362, 14'd15760, 14'd14846, 14'd13361, 14'd11362,  14'd8927,  14'd6149,  14'd3134,
    14'd10703, 14'd14846, 14'd13984, 14'd12585, 14'd10703,  14'd8409,  14'd5792,  14'd2953,
     14'd9632, 14'd13361, 14'd12585, 14'd11326,  14'd9632,  14'd7568,  14'd5213,  14'd2657,
     14'd8192, 14'd11362, 14'd10703,  14'd9632,  14'd8192,  14'd6436,  14'd4433,  14'd2260,
     14'd6436,  14'd8927,  14'd8409,  14'd7568,  14'd6436,  14'd5057,  14'd3483,  14'd1775,
     14'd4433,  14'd6149,  14'd5792,  14'd5213,  14'd4433,  14'd3483,  14'd2399,  14'd1223,
     14'd2260,  14'd3134,  14'd2953,  14'd2657,  14'd2260,  14'd1775,  14'd1223,   14'd623
  };

endpackage

// ----- rtl/core/jdq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module jdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/jpeg_dequantizer_aan_scaled_unit.sv -----
// JPEG dequantizer with AAN IDCT prescaled quantization tables (top level).
//
// Holds NUM_TABLES quantization tables of 64 entries in one RAM, stored in
// row-major order and premultiplied by the AAN IDCT prescale (x8192). A load
// beat (mode 0) writes load_value * prescale into the entry of the given
// table at the natural position of the zigzag index and gives no result; a
// table id at or above NUM_TABLES is dropped. A dequantize beat (mode 1)
// gives one result: the natural position and floor(coefficient * entry / 256);
// an out-of-range table id yields zero. Rate: one beat per cycle sustained while
// in_stall is low, loads and dequantizes mixed freely. A dequantize result passes
// the synchronous table RAM read register and then the 12x22 multiply into the
// output register. Loads write the RAM in the cycle they are accepted, so a
// dequantize right behind a load sees the new value with no forwarding. The table
// RAM is not cleared at reset; dequantizing an entry that was never loaded returns
// an undefined value. Results wait in the output register plus one stage of
// buffering, so input is stalled only when both are full.
module jpeg_dequantizer_aan_scaled_unit #(
  parameter int NUM_TABLES = jdq_pkg::NUM_TABLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jdq_pkg::MODE_W-1:0]      in_mode,
  input  logic [jdq_pkg::TID_W-1:0]       in_table_id,
  input  logic [jdq_pkg::POS_W-1:0]       in_zigzag_position,
  input  logic [jdq_pkg::VAL_W-1:0]       in_load_value,
  input  logic signed [jdq_pkg::COEF_W-1:0] in_coefficient,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [jdq_pkg::POS_W-1:0]       out_natural_position,
  output logic signed [jdq_pkg::RES_W-1:0] out_dequantized
);

  import jdq_pkg::*;

  localparam int DEPTH  = NUM_TABLES * 64;
  localparam int ADDR_W = $clog2(DEPTH);

  // ---- accept stage: zigzag map, load scaling, RAM access ----
  logic              in_acc;
  logic              out_ready;
  logic              s1_adv;
  logic              tid_ok;
  logic [POS_W-1:0]  nat;
  logic [ADDR_W-1:0] addr;
  logic [ENTRY_W-1:0] entry_nxt;
  logic              wr_en;
  logic              rd_en;
  logic [ENTRY_W-1:0] rd_data;

  // stage 1 holds a dequantize beat while its RAM data is on rd_data
  logic                     s1_v_r;
  logic [POS_W-1:0]         s1_nat_r;
  logic signed [COEF_W-1:0] s1_coef_r;
  logic                     s1_tid_ok_r;

  logic [ENTRY_W-1:0]       s1_entry;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] shifted;
  logic signed [RES_W-1:0]  res_nxt;

  // output register
  logic                    out_valid_r;
  logic [POS_W-1:0]        out_nat_r;
  logic signed [RES_W-1:0] out_res_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_v_r && out_ready;
  assign in_stall  = s1_v_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  assign tid_ok    = 32'(in_table_id) < NUM_TABLES;
  assign nat       = ZZ_TO_NAT[in_zigzag_position];
  // table*64 + nat; low bits of the concatenation cover any table count
  assign addr      = ADDR_W'({in_table_id, nat});
  assign entry_nxt = ENTRY_W'(in_load_value) * ENTRY_W'(PRESCALE[nat]);

  assign wr_en = in_acc && (in_mode == MODE_LOAD) && tid_ok;
  assign rd_en = in_acc && (in_mode == MODE_DEQUANT);

  jdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (entry_nxt),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // ---- stage 1: RAM data valid, multiply ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rd_en) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
    if (rd_en) begin
      s1_nat_r    <= nat;
      s1_coef_r   <= in_coefficient;
      s1_tid_ok_r <= tid_ok;
    end
  end

  assign s1_entry = s1_tid_ok_r ? rd_data : '0;
  assign prod_nxt = PROD_W'(s1_coef_r) * $signed(PROD_W'({1'b0, s1_entry}));
  assign shifted  = prod_nxt >>> SHIFT;   // floor division by 256
  assign res_nxt  = shifted[RES_W-1:0];

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_v_r;
    end
    if (s1_adv) begin
      out_nat_r <= s1_nat_r;
      out_res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_natural_position = out_nat_r;
  assign out_dequantized      = out_res_r;

`ifndef SYNTH
  // a dequantize beat always lands in stage 1
  a_deq_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_DEQUANT) |=> s1_v_r)
    else $error("dequantize beat lost before stage 1");

  // a load beat never creates a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_LOAD) |=> !s1_v_r)
    else $error("load beat produced a pending result");

  // held stage 1 keeps its payload and its RAM read data
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_valid_r && out_stall) |=>
      (s1_v_r && $stable(s1_nat_r) && $stable(rd_data)))
    else $error("stage 1 changed while held");

  // a result only appears from an occupied stage 1
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r))
    else $error("result without a stage 1 beat");
`endif

endmodule
